### rtl/mnbt_pkg.sv
// mnbt_pkg: shared types, codes and constants of the MIDI note/button tracker.
// Used by every module under rtl/; depends on nothing.
package mnbt_pkg;

  localparam int NUM_CTL   = 11;
  localparam int PCLASSES  = 12;
  localparam int HELD_W    = 16;
  localparam int PER_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  typedef enum logic [1:0] {
    CMD_MIDI = 2'd0,
    CMD_KEY  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;

  localparam logic KIND_ECHO   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND_EN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND_VEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_PERIOD = 3'd4;

  localparam logic [3:0] LAST_CTL = 4'd10;

  // pitch-class membership of each control, bit p = pitch class p
  localparam logic [PCLASSES-1:0] CTL_MASK [NUM_CTL] = '{
    12'h001, 12'h004, 12'h002, 12'h008, 12'hAA0, 12'h540,
    12'h001, 12'h004, 12'h010, 12'hAB5, 12'h54A
  };

  typedef struct packed {
    logic [1:0]  command;
    logic [23:0] midi_message;
    logic [5:0]  key_index;
    logic        key_on;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        echo_status;
    logic [7:0]        echo_note;
    logic [6:0]        echo_velocity;
    logic [3:0]        control_index;
    logic [HELD_W-1:0] held_frames;
    logic              repeat_select;
    logic              last;
  } out_item_t;

  // decoded key event, valid for the item on the input port
  typedef struct packed {
    logic       newly;   // event presses a key that was released
    logic [7:0] key;     // key number within the window
  } key_stat_t;

  typedef struct packed {
    logic              start;
    logic [HELD_W-1:0] dividend;
    logic [PER_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } div_rsp_t;

endpackage

### rtl/midi_note_button_tracker_unit.sv
// midi_note_button_tracker_unit: top level, sequencer, config registers,
// held-frame counters and output register. Depends on mnbt_pkg,
// mnbt_key_store and mnbt_rem_unit.
//
// Usage:
// - cfg_we/cfg_index/cfg_wdata write one config register per cycle. The user
//   must write only while the block is idle; the block has no guard for it.
// - in_valid/in_ready carry one request: a MIDI short message, a direct
//   key event or a frame tick. A request is taken only in the idle state.
// - out_valid/out_ready carry results: a note-on echo for a key that
//   newly turns on (sound enabled), or eleven control reports per tick,
//   the last with last=1.
// - Key requests update the pressed bits in the accept cycle; an echo passes
//   through the stage register to the output register. A request with no result
//   leaves in_ready high, so one can follow every cycle.
// - A tick walks the controls: CALC updates the counter, DIV waits on the
//   shared remainder unit (held mod period, two bits a cycle), PUSH hands the
//   report to the output register.
// - The output register holds a result until out_ready; while it is
//   full the sequencer waits with the next result, and input stays
//   blocked until the tick or echo is fully handed off.
// - Synchronous active-low reset: keys released, counters zero, config
//   at defaults (velocity 127, period 8), no output pending.
module midi_note_button_tracker_unit #(
  parameter int KEYS    = 60,
  parameter int OCTAVES = 5
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [mnbt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mnbt_pkg::CFG_DAT_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  mnbt_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output mnbt_pkg::out_item_t                   out_data
);
  import mnbt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_PUSH = 4'b1000
  } state_t;

  // config registers
  logic [6:0]       in_base_r;
  logic             snd_en_r;
  logic [6:0]       snd_vel_r;
  logic [6:0]       snd_base_r;
  logic [PER_W-1:0] period_r;

  state_t            state_r, state_nxt;
  logic [3:0]        ctl_r, ctl_nxt;
  logic [HELD_W-1:0] held_r [NUM_CTL];
  logic [HELD_W-1:0] h_nxt;
  logic [HELD_W-1:0] h_r;
  out_item_t         stage_r, stage_nxt;
  out_item_t         out_data_r;
  logic              out_valid_r;
  logic              in_acc;
  logic              push_ok;
  logic              ctl_act;
  logic              rep;
  logic [11:0]       pc_act;
  key_stat_t         key_stat;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign push_ok  = (state_r == ST_PUSH) && (!out_valid_r || out_ready);

  // ---------------------------------------------------------------------
  // config port
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_base_r  <= 7'd0;
      snd_en_r   <= 1'b0;
      snd_vel_r  <= 7'd127;
      snd_base_r <= 7'd0;
      period_r   <= 8'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INPUT_BASE: in_base_r  <= cfg_wdata[6:0];
        CFG_SOUND_EN:   snd_en_r   <= cfg_wdata[0];
        CFG_SOUND_VEL:  snd_vel_r  <= cfg_wdata[6:0];
        CFG_SOUND_BASE: snd_base_r <= cfg_wdata[6:0];
        CFG_REP_PERIOD: period_r   <= cfg_wdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // key bits and pitch-class activity
  // ---------------------------------------------------------------------
  mnbt_key_store #(
    .KEYS    (KEYS),
    .OCTAVES (OCTAVES)
  ) u_keys (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .upd      (in_acc),
    .cfg_base (in_base_r),
    .key_stat (key_stat),
    .pc_act   (pc_act)
  );

  // control is active when any key of its pitch-class group is down
  assign ctl_act = |(pc_act & CTL_MASK[ctl_r]);

  always_comb begin
    if (!ctl_act) begin
      h_nxt = '0;
    end else if (held_r[ctl_r] == '1) begin
      h_nxt = '1;
    end else begin
      h_nxt = held_r[ctl_r] + HELD_W'(1);
    end
  end

  // shared remainder unit, started once per control
  assign div_req.start    = (state_r == ST_CALC);
  assign div_req.dividend = h_nxt;
  assign div_req.divisor  = period_r;

  mnbt_rem_unit u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  // zero period: only held == 1 pulses
  assign rep = (h_r == HELD_W'(1)) ||
               ((h_r != '0) && (period_r != '0) && div_rsp.rem_zero);

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    ctl_nxt   = ctl_r;
    stage_nxt = stage_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.command == CMD_TICK) begin
            ctl_nxt   = '0;
            state_nxt = ST_CALC;
          end else if (key_stat.newly && snd_en_r) begin
            stage_nxt               = '0;
            stage_nxt.kind          = KIND_ECHO;
            stage_nxt.echo_status   = STATUS_NOTE_ON;
            stage_nxt.echo_note     = {1'b0, snd_base_r} + key_stat.key;
            stage_nxt.echo_velocity = snd_vel_r;
            state_nxt               = ST_PUSH;
          end
        end
      end
      ST_CALC: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          stage_nxt               = '0;
          stage_nxt.kind          = KIND_REPORT;
          stage_nxt.control_index = ctl_r;
          stage_nxt.held_frames   = h_r;
          stage_nxt.repeat_select = rep;
          stage_nxt.last          = (ctl_r == LAST_CTL);
          state_nxt               = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_ok) begin
          if ((stage_r.kind == KIND_ECHO) || stage_r.last) begin
            state_nxt = ST_IDLE;
          end else begin
            ctl_nxt   = ctl_r + 4'd1;
            state_nxt = ST_CALC;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctl_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CTL; i++) begin
        held_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ctl_r   <= ctl_nxt;
      if (state_r == ST_CALC) begin
        held_r[ctl_r] <= h_nxt;
      end
      if (push_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
    if (state_r == ST_CALC) begin
      h_r <= h_nxt;
    end
    if (push_ok) begin
      out_data_r <= stage_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_div_to_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_rsp.done) |=> (state_r == ST_PUSH))
    else $error("remainder done did not move sequencer to push");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("remainder unit started while busy");

  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.repeat_select) |-> (out_data_r.held_frames != '0))
    else $error("repeat select with zero held count");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && stage_r.kind == KIND_REPORT && stage_r.last) |=>
      (state_r == ST_IDLE))
    else $error("tick did not end after last report");

endmodule

### rtl/mnbt_key_store.sv
// mnbt_key_store: key pressed bits, event decode and pitch-class activity.
// Depends on mnbt_pkg.
module mnbt_key_store #(
  parameter int KEYS    = 60,
  parameter int OCTAVES = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mnbt_pkg::in_item_t  in_data,
  input  logic                upd,
  input  logic [6:0]          cfg_base,
  output mnbt_pkg::key_stat_t key_stat,
  output logic [11:0]         pc_act
);
  import mnbt_pkg::*;

  localparam int KW = $clog2(KEYS);
  localparam logic [7:0] KEYS8 = 8'(KEYS);

  logic [KEYS-1:0] pressed_r;
  logic [KEYS-1:0] pressed_nxt;
  logic            hit;
  logic            on;
  logic [7:0]      key;
  logic [7:0]      status;
  logic [7:0]      note;
  logic [7:0]      diff;
  logic [OCTAVES-1:0] term [PCLASSES];

  assign status = in_data.midi_message[7:0];
  assign note   = in_data.midi_message[15:8];
  assign diff   = note - {1'b0, cfg_base};

  always_comb begin
    hit = 1'b0;
    on  = 1'b0;
    key = diff;
    case (in_data.command)
      CMD_MIDI: begin
        on  = (status == STATUS_NOTE_ON) && (in_data.midi_message[23:16] != 8'd0);
        hit = ((status == STATUS_NOTE_OFF) || (status == STATUS_NOTE_ON)) &&
              !note[7] && (note >= {1'b0, cfg_base}) && (diff < KEYS8);
      end
      CMD_KEY: begin
        key = {2'b00, in_data.key_index};
        on  = in_data.key_on;
        hit = key < KEYS8;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  assign key_stat.key   = key;
  assign key_stat.newly = hit && on && !pressed_r[key[KW-1:0]];

  always_comb begin
    pressed_nxt = pressed_r;
    if (upd && hit) begin
      pressed_nxt[key[KW-1:0]] = on;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= '0;
    end else begin
      pressed_r <= pressed_nxt;
    end
  end

  // keys past KEYS count as released
  for (genvar p = 0; p < PCLASSES; p++) begin : g_pc
    for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
      if (o * PCLASSES + p < KEYS) begin : g_key
        assign term[p][o] = pressed_r[o * PCLASSES + p];
      end else begin : g_pad
        assign term[p][o] = 1'b0;
      end
    end
    assign pc_act[p] = |term[p];
  end

endmodule

### rtl/mnbt_rem_unit.sv
// mnbt_rem_unit: shared remainder unit, held count modulo repeat period,
// restoring division at two bits per cycle. Depends on mnbt_pkg.
module mnbt_rem_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  mnbt_pkg::div_req_t div_req,
  output mnbt_pkg::div_rsp_t div_rsp
);
  import mnbt_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [2:0]        cnt_r;
  logic [PER_W-1:0]  rem_r;
  logic [PER_W-1:0]  rem_nxt;
  logic [PER_W-1:0]  rem_mid;
  logic [HELD_W-1:0] dvd_r;
  logic [PER_W-1:0]  dvs_r;

  function automatic logic [PER_W-1:0] rem_step(input logic [PER_W-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [PER_W-1:0] dvs);
    logic [PER_W:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, dvs}) begin
      t = t - {1'b0, dvs};
    end
    return t[PER_W-1:0];
  endfunction

  assign rem_mid = rem_step(rem_r, dvd_r[HELD_W-1], dvs_r);
  assign rem_nxt = rem_step(rem_mid, dvd_r[HELD_W-2], dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 3'd7);
      if (div_req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_req.start) begin
      dvd_r <= div_req.dividend;
      dvs_r <= div_req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[HELD_W-3:0], 2'b00};
      rem_r <= rem_nxt;
    end
  end

  assign div_rsp.busy     = busy_r;
  assign div_rsp.done     = done_r;
  assign div_rsp.rem_zero = (rem_r == '0);

endmodule
